>>> design/bta_pkg.sv
`default_nettype none
package bta_pkg;

  localparam int POOL_DEPTH = 4096;
  localparam int OVERHEAD_WORDS = 4;
  localparam int RAM_AW = $clog2(POOL_DEPTH);
  localparam int WORD_W = 16;
  localparam int WA_W = 18;
  localparam int SZ_W = 18;
  localparam int PW_W = 13;
  localparam int CNT_W = 13;
  localparam int OP_W = 2;
  localparam int FLD_W = 12;
  localparam int ADDR_SPACE = 4096;
  localparam int POOL_CAP = (POOL_DEPTH < ADDR_SPACE) ? POOL_DEPTH : ADDR_SPACE;

  typedef logic [WA_W-1:0] wa_t;
  typedef logic signed [SZ_W-1:0] sz_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam wa_t POOL_LIMIT = WA_W'(POOL_DEPTH);
  localparam logic [PW_W-1:0] POOL_CAP_W = PW_W'(POOL_CAP);
  localparam logic [PW_W-1:0] PW_RESET = PW_W'(4096);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_DONE  = 2'd3
  } op_e;

  typedef enum logic [5:0] {
    S_IDLE, S_RES, S_OK,
    S_I0, S_I1, S_I2, S_I3,
    S_A_LOOP, S_A_CHK, S_A_NXT, S_A_FOUND, S_A_SPL, S_A_NEG, S_A_NEG1, S_A_Z1, S_A_Z2,
    S_F_LOOP, S_F_CHK, S_F_NEG, S_F_MR, S_F_PUSH, S_F_P1, S_F_P2, S_F_P3, S_F_P4,
    S_F_PE2, S_F_L0, S_F_L1, S_F_L2,
    S_SS0, S_SS1,
    S_UL0, S_UL1, S_UL2, S_UL3, S_UL4, S_UL5,
    S_MR0, S_MR1, S_MR2, S_MR3, S_MR4, S_MR5
  } state_e;

  typedef struct packed {
    logic  en;
    logic  we;
    wa_t   addr;
    word_t wdata;
  } mem_req_t;

  function automatic sz_t sext(word_t w);
    return $signed({{(SZ_W-WORD_W){w[WORD_W-1]}}, w});
  endfunction

  function automatic wa_t mag(sz_t s);
    sz_t a;
    a = (s < 0) ? -s : s;
    return wa_t'(a);
  endfunction

  function automatic mem_req_t mem_rd(wa_t a);
    mem_req_t r;
    r.en = 1'b1;
    r.we = 1'b0;
    r.addr = a;
    r.wdata = '0;
    return r;
  endfunction

  function automatic mem_req_t mem_wr(wa_t a, word_t d);
    mem_req_t r;
    r.en = (a < POOL_LIMIT);
    r.we = (a < POOL_LIMIT);
    r.addr = a;
    r.wdata = d;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/bta_if.sv
`default_nettype none
interface bta_req_if;
  import bta_pkg::*;
  logic valid;
  logic ready;
  logic [OP_W-1:0] opcode;
  logic [FLD_W-1:0] request_words;
  logic [FLD_W-1:0] free_address;
  modport source(output valid, opcode, request_words, free_address, input ready);
  modport sink(input valid, opcode, request_words, free_address, output ready);
endinterface

interface bta_rsp_if;
  import bta_pkg::*;
  logic valid;
  logic ready;
  logic status;
  logic [FLD_W-1:0] payload_address;
  modport source(output valid, status, payload_address, input ready);
  modport sink(input valid, status, payload_address, output ready);
endinterface
`default_nettype wire

>>> design/bta_ram.sv
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

>>> design/bta_core.sv
`default_nettype none
module bta_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  bta_req_if.sink                         req_i,
  bta_rsp_if.source                       rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bta_pkg::PW_W-1:0]   cfg_wdata_i,
  output bta_pkg::mem_req_t               mem_o,
  input  wire bta_pkg::word_t             mem_rdata_i
);
  import bta_pkg::*;

  state_e state_q, state_d, ss_ret_q, ss_ret_d, ul_ret_q, ul_ret_d, mr_ret_q, mr_ret_d;
  wa_t ss_b_q, ss_b_d, ul_b_q, ul_b_d, mr_b_q, mr_b_d, mr_r_q, mr_r_d;
  wa_t b_q, b_d, pos_q, pos_d, blk_q, blk_d;
  sz_t ss_v_q, ss_v_d, sz_q, sz_d, need_q, need_d;
  word_t ul_n_q, ul_n_d, ul_p_q, ul_p_d, mr_t_q, mr_t_d, p_q, p_d;
  word_t cur_q, cur_d, start_q, start_d, head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PW_W-1:0] active_q, active_d, pw_q, pw_d, init_w;
  logic empty_q, empty_d, rdy_q, rdy_d, rd_oob_q, rd_oob_d;
  logic st_q, st_d, rv_q, rv_d, rs_q, rs_d;
  logic [FLD_W-1:0] ad_q, ad_d, ra_q, ra_d;
  mem_req_t mreq;
  word_t rdv;
  sz_t rs;
  wa_t rm, act_w, ss_m;

  assign rdv = rd_oob_q ? '0 : mem_rdata_i;
  assign rs = sext(rdv);
  assign rm = mag(rs);
  assign act_w = WA_W'(active_q);
  assign ss_m = mag(ss_v_q);
  assign init_w = (pw_q > POOL_CAP_W) ? POOL_CAP_W : pw_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rv_q;
  assign rsp_o.status = rs_q;
  assign rsp_o.payload_address = ra_q;
  assign mem_o = mreq;

  always_comb begin
    state_d = state_q; ss_ret_d = ss_ret_q; ul_ret_d = ul_ret_q; mr_ret_d = mr_ret_q;
    ss_b_d = ss_b_q; ul_b_d = ul_b_q; mr_b_d = mr_b_q; mr_r_d = mr_r_q;
    b_d = b_q; pos_d = pos_q; blk_d = blk_q;
    ss_v_d = ss_v_q; sz_d = sz_q; need_d = need_q;
    ul_n_d = ul_n_q; ul_p_d = ul_p_q; mr_t_d = mr_t_q; p_d = p_q;
    cur_d = cur_q; start_d = start_q; head_d = head_q; cnt_d = cnt_q;
    active_d = active_q; pw_d = pw_q; empty_d = empty_q; rdy_d = rdy_q;
    st_d = st_q; ad_d = ad_q; rs_d = rs_q; ra_d = ra_q;
    rv_d = rv_q & ~rsp_o.ready;
    mreq = '0;

    if (cfg_we_i) begin
      pw_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          st_d = 1'b1;
          ad_d = '0;
          case (op_e'(req_i.opcode))
            OP_ALLOC: begin
              need_d = $signed({{(SZ_W-FLD_W){1'b0}}, req_i.request_words})
                       + sz_t'(OVERHEAD_WORDS);
              cur_d = head_q;
              start_d = head_q;
              cnt_d = '0;
              if (!rdy_q || req_i.request_words == '0 || empty_q) begin
                state_d = S_RES;
              end else begin
                state_d = S_A_LOOP;
              end
            end
            OP_FREE: begin
              b_d = WA_W'(req_i.free_address) - wa_t'(3);
              pos_d = '0;
              cnt_d = '0;
              if (!rdy_q || req_i.free_address < FLD_W'(3)) begin
                state_d = S_RES;
              end else begin
                state_d = S_F_LOOP;
              end
            end
            OP_INIT: begin
              if (init_w <= PW_W'(OVERHEAD_WORDS)) begin
                state_d = S_RES;
              end else begin
                active_d = init_w;
                state_d = S_I0;
              end
            end
            default: begin
              rdy_d = 1'b0;
              state_d = S_OK;
            end
          endcase
        end
      end
      S_OK: begin
        st_d = 1'b0;
        ad_d = '0;
        state_d = S_RES;
      end
      S_RES: begin
        if (!rv_q || rsp_o.ready) begin
          rv_d = 1'b1;
          rs_d = st_q;
          ra_d = ad_q;
          state_d = S_IDLE;
        end
      end

      // one free block spanning the pool
      S_I0: begin
        mreq = mem_wr('0, WORD_W'(active_q));
        state_d = S_I1;
      end
      S_I1: begin
        mreq = mem_wr(act_w - wa_t'(1), WORD_W'(active_q));
        state_d = S_I2;
      end
      S_I2: begin
        mreq = mem_wr(wa_t'(1), '0);
        state_d = S_I3;
      end
      S_I3: begin
        mreq = mem_wr(wa_t'(2), '0);
        head_d = '0;
        empty_d = 1'b0;
        rdy_d = 1'b1;
        state_d = S_OK;
      end

      // next-fit walk over the free list
      S_A_LOOP: begin
        if (cnt_q > active_q || WA_W'(cur_q) >= act_w) begin
          state_d = S_RES;
        end else begin
          mreq = mem_rd(WA_W'(cur_q));
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (rs >= need_q) begin
          head_d = cur_q;
          sz_d = rs;
          state_d = S_A_FOUND;
        end else begin
          mreq = mem_rd(WA_W'(cur_q) + wa_t'(1));
          state_d = S_A_NXT;
        end
      end
      S_A_NXT: begin
        cur_d = rdv;
        cnt_d = cnt_q + CNT_W'(1);
        state_d = (rdv == start_q) ? S_RES : S_A_LOOP;
      end
      S_A_FOUND: begin
        if (sz_q >= need_q + sz_t'(OVERHEAD_WORDS + 1)) begin
          ss_b_d = WA_W'(cur_q);
          ss_v_d = sz_q - need_q;
          ss_ret_d = S_A_SPL;
          state_d = S_SS0;
        end else begin
          blk_d = WA_W'(cur_q);
          ul_b_d = WA_W'(cur_q);
          ul_ret_d = S_A_NEG;
          state_d = S_UL0;
        end
      end
      S_A_SPL: begin
        // hand out the right end of the split block
        blk_d = WA_W'(cur_q) + wa_t'(ss_v_q);
        ss_b_d = WA_W'(cur_q) + wa_t'(ss_v_q);
        ss_v_d = need_q;
        ss_ret_d = S_A_NEG;
        state_d = S_SS0;
      end
      S_A_NEG: begin
        mreq = mem_rd(blk_q);
        state_d = S_A_NEG1;
      end
      S_A_NEG1: begin
        ss_b_d = blk_q;
        ss_v_d = -rs;
        ss_ret_d = S_A_Z1;
        state_d = S_SS0;
      end
      S_A_Z1: begin
        mreq = mem_wr(blk_q + wa_t'(1), '0);
        state_d = S_A_Z2;
      end
      S_A_Z2: begin
        mreq = mem_wr(blk_q + wa_t'(2), '0);
        st_d = 1'b0;
        ad_d = FLD_W'(blk_q + wa_t'(3));
        state_d = S_RES;
      end

      // check the address by walking blocks from word 0
      S_F_LOOP: begin
        if (cnt_q > active_q || pos_q >= act_w) begin
          state_d = S_RES;
        end else begin
          mreq = mem_rd(pos_q);
          state_d = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (rm <= wa_t'(OVERHEAD_WORDS) || pos_q + rm > act_w) begin
          state_d = S_RES;
        end else if (pos_q == b_q) begin
          sz_d = rs;
          state_d = (rs < 0) ? S_F_NEG : S_RES;
        end else if (pos_q > b_q) begin
          state_d = S_RES;
        end else begin
          pos_d = pos_q + rm;
          cnt_d = cnt_q + CNT_W'(1);
          state_d = S_F_LOOP;
        end
      end
      S_F_NEG: begin
        ss_b_d = b_q;
        ss_v_d = -sz_q;
        ss_ret_d = S_F_MR;
        state_d = S_SS0;
      end
      S_F_MR: begin
        mr_b_d = b_q;
        mr_ret_d = S_F_PUSH;
        state_d = S_MR0;
      end
      S_F_PUSH: begin
        if (!empty_q) begin
          mreq = mem_rd(WA_W'(head_q) + wa_t'(2));
          state_d = S_F_P1;
        end else begin
          mreq = mem_wr(b_q + wa_t'(1), WORD_W'(b_q));
          state_d = S_F_PE2;
        end
      end
      S_F_P1: begin
        p_d = rdv;
        mreq = mem_wr(b_q + wa_t'(1), head_q);
        state_d = S_F_P2;
      end
      S_F_P2: begin
        mreq = mem_wr(b_q + wa_t'(2), p_q);
        state_d = S_F_P3;
      end
      S_F_P3: begin
        mreq = mem_wr(WA_W'(head_q) + wa_t'(2), WORD_W'(b_q));
        state_d = S_F_P4;
      end
      S_F_P4: begin
        mreq = mem_wr(WA_W'(p_q) + wa_t'(1), WORD_W'(b_q));
        head_d = WORD_W'(b_q);
        state_d = S_F_L0;
      end
      S_F_PE2: begin
        mreq = mem_wr(b_q + wa_t'(2), WORD_W'(b_q));
        empty_d = 1'b0;
        head_d = WORD_W'(b_q);
        state_d = S_F_L0;
      end
      S_F_L0: begin
        if (b_q == '0) begin
          state_d = S_OK;
        end else begin
          mreq = mem_rd(b_q - wa_t'(1));
          state_d = S_F_L1;
        end
      end
      S_F_L1: begin
        if (rm != '0 && rm <= b_q) begin
          blk_d = b_q - rm;
          mreq = mem_rd(b_q - rm);
          state_d = S_F_L2;
        end else begin
          state_d = S_OK;
        end
      end
      S_F_L2: begin
        if (rs > 0) begin
          mr_b_d = blk_q;
          mr_ret_d = S_OK;
          state_d = S_MR0;
        end else begin
          state_d = S_OK;
        end
      end

      // write size to header and footer
      S_SS0: begin
        mreq = mem_wr(ss_b_q, WORD_W'(ss_v_q));
        state_d = (ss_m != '0) ? S_SS1 : ss_ret_q;
      end
      S_SS1: begin
        mreq = mem_wr(ss_b_q + ss_m - wa_t'(1), WORD_W'(ss_v_q));
        state_d = ss_ret_q;
      end

      // take a block out of the free list
      S_UL0: begin
        if (empty_q) begin
          state_d = ul_ret_q;
        end else begin
          mreq = mem_rd(ul_b_q + wa_t'(1));
          state_d = S_UL1;
        end
      end
      S_UL1: begin
        ul_n_d = rdv;
        mreq = mem_rd(ul_b_q + wa_t'(2));
        state_d = S_UL2;
      end
      S_UL2: begin
        ul_p_d = rdv;
        if (ul_b_q == WA_W'(head_q)) begin
          head_d = ul_n_q;
        end
        if (WA_W'(ul_n_q) == ul_b_q) begin
          empty_d = 1'b1;
        end
        mreq = mem_wr(WA_W'(ul_n_q) + wa_t'(2), rdv);
        state_d = S_UL3;
      end
      S_UL3: begin
        mreq = mem_wr(WA_W'(ul_p_q) + wa_t'(1), ul_n_q);
        state_d = S_UL4;
      end
      S_UL4: begin
        mreq = mem_wr(ul_b_q + wa_t'(1), '0);
        state_d = S_UL5;
      end
      S_UL5: begin
        mreq = mem_wr(ul_b_q + wa_t'(2), '0);
        state_d = ul_ret_q;
      end

      // absorb a free right neighbour
      S_MR0: begin
        mreq = mem_rd(mr_b_q);
        state_d = S_MR1;
      end
      S_MR1: begin
        if (mr_b_q + rm >= act_w) begin
          state_d = mr_ret_q;
        end else begin
          mr_r_d = mr_b_q + rm;
          mreq = mem_rd(mr_b_q + rm);
          state_d = S_MR2;
        end
      end
      S_MR2: begin
        if (rs < 0) begin
          state_d = mr_ret_q;
        end else begin
          ul_b_d = mr_r_q;
          ul_ret_d = S_MR3;
          state_d = S_UL0;
        end
      end
      S_MR3: begin
        mreq = mem_rd(mr_r_q);
        state_d = S_MR4;
      end
      S_MR4: begin
        mr_t_d = rdv;
        mreq = mem_rd(mr_b_q);
        state_d = S_MR5;
      end
      S_MR5: begin
        ss_b_d = mr_b_q;
        ss_v_d = sext(mr_t_q) + rs;
        ss_ret_d = mr_ret_q;
        state_d = S_SS0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_oob_d = (mreq.addr >= POOL_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      empty_q <= 1'b1;
      rdy_q <= 1'b0;
      pw_q <= PW_RESET;
      active_q <= '0;
      rv_q <= 1'b0;
      rd_oob_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      empty_q <= empty_d;
      rdy_q <= rdy_d;
      pw_q <= pw_d;
      active_q <= active_d;
      rv_q <= rv_d;
      rd_oob_q <= rd_oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ss_ret_q <= ss_ret_d; ul_ret_q <= ul_ret_d; mr_ret_q <= mr_ret_d;
    ss_b_q <= ss_b_d; ul_b_q <= ul_b_d; mr_b_q <= mr_b_d; mr_r_q <= mr_r_d;
    b_q <= b_d; pos_q <= pos_d; blk_q <= blk_d;
    ss_v_q <= ss_v_d; sz_q <= sz_d; need_q <= need_d;
    ul_n_q <= ul_n_d; ul_p_q <= ul_p_d; mr_t_q <= mr_t_d; p_q <= p_d;
    cur_q <= cur_d; start_q <= start_d; cnt_q <= cnt_d;
    st_q <= st_d; ad_q <= ad_d; rs_q <= rs_d; ra_q <= ra_d;
  end
endmodule
`default_nettype wire

>>> design/boundary_tag_heap_allocator.sv
`default_nettype none
// Channel   Dir  Payload                                  Handshake
// req_i     in   opcode, request_words, free_address      valid/ready
// rsp_o     out  status, payload_address                  valid/ready
// cfg       in   cfg_wdata_i (pool_words)                 cfg_we_i
//
// One request at a time; every memory access goes through the single RAM port, whose read data is registered.
// Allocate walks the free list from its head; free walks the blocks from word 0.
// Reset empties the list and clears ready; the pool RAM is not cleared.
// A finished result waits in the output register while the next request is taken.
module boundary_tag_heap_allocator (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  bta_req_if.sink                       req_i,
  bta_rsp_if.source                     rsp_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [bta_pkg::PW_W-1:0] cfg_wdata_i
);
  import bta_pkg::*;

  mem_req_t mreq;
  word_t    rdata;

  bta_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_o       (mreq),
    .mem_rdata_i (rdata)
  );

  bta_ram #(
    .WIDTH (WORD_W),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mreq.en),
    .we_i    (mreq.en & mreq.we),
    .addr_i  (mreq.addr[RAM_AW-1:0]),
    .wdata_i (mreq.wdata),
    .rdata_o (rdata)
  );

  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  a_write_in_pool : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.we |-> (mreq.en && mreq.addr < POOL_LIMIT))
    else $error("pool write outside the RAM");

  a_fail_zero_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.payload_address == '0))
    else $error("failed result carries an address");
endmodule
`default_nettype wire

>>> tb/sv/tb_boundary_tag_heap_allocator.sv
`timescale 1ns / 100ps
module tb_boundary_tag_heap_allocator;
  import bta_pkg::*;

  localparam int HEAP_WORDS = 4096;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    op_e              op;
    logic [FLD_W-1:0] words;
    logic [FLD_W-1:0] addr;
  } request_t;

  typedef struct {
    logic             status;
    logic [FLD_W-1:0] payload;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [PW_W-1:0] cfg_wdata_i;

  bta_req_if req ();
  bta_rsp_if rsp ();

  boundary_tag_heap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow heap state
  logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
  int unsigned       free_head;
  bit                free_empty;
  bit                heap_ready;
  logic [PW_W-1:0]   pool_cfg;
  int unsigned       active_words;

  request_t          request_q[$];
  outcome_t          outcome_q[$];
  logic [FLD_W-1:0]  live_addrs[$];
  request_t          cur_req;
  int                errors;
  int                send_gap;
  int                sink_stall;
  int                quiet_cycles;
  bit                quiet;

  function automatic int unsigned heap_rd(int unsigned a);
    return (a < HEAP_WORDS) ? int'(heap_mem[a]) : 0;
  endfunction

  function automatic void heap_wr(int unsigned a, int v);
    if (a < HEAP_WORDS) heap_mem[a] = v[15:0];
  endfunction

  function automatic int tag_size(int unsigned b);
    logic [15:0] w;
    w = 16'(heap_rd(b));
    return int'($signed(w));
  endfunction

  function automatic int unsigned tag_mag(int unsigned b);
    int s;
    s = tag_size(b);
    return (s < 0) ? -s : s;
  endfunction

  function automatic void put_size(int unsigned b, int v);
    int unsigned m;
    m = (v < 0) ? -v : v;
    heap_wr(b, v);
    if (m > 0) heap_wr(b + m - 1, v);
  endfunction

  function automatic void unlink_free(int unsigned b);
    int unsigned n, p;
    if (free_empty) return;
    n = heap_rd(b + 1);
    p = heap_rd(b + 2);
    if (b == free_head) free_head = n;
    if (n == b) free_empty = 1;
    heap_wr(n + 2, p);
    heap_wr(p + 1, n);
    heap_wr(b + 1, 0);
    heap_wr(b + 2, 0);
  endfunction

  function automatic void push_free(int unsigned b);
    int unsigned h, p;
    if (!free_empty) begin
      h = free_head;
      p = heap_rd(h + 2);
      heap_wr(b + 1, h);
      heap_wr(b + 2, p);
      heap_wr(h + 2, b);
      heap_wr(p + 1, b);
    end else begin
      heap_wr(b + 1, b);
      heap_wr(b + 2, b);
      free_empty = 0;
    end
    free_head = b;
  endfunction

  function automatic void coalesce_right(int unsigned b);
    int unsigned r;
    r = b + tag_mag(b);
    if (r >= active_words || tag_size(r) < 0) return;
    unlink_free(r);
    put_size(b, tag_size(r) + tag_size(b));
  endfunction

  // walk the blocks from word 0 to confirm the target is a live allocation
  function automatic bit block_is_live(int unsigned target);
    int unsigned pos, steps, m;
    pos = 0;
    for (steps = 0; steps <= active_words && pos < active_words; steps++) begin
      m = tag_mag(pos);
      if (m <= OVERHEAD_WORDS || pos + m > active_words) return 0;
      if (pos == target) return tag_size(pos) < 0;
      if (pos > target) return 0;
      pos += m;
    end
    return 0;
  endfunction

  function automatic bit heap_alloc(int unsigned want, output int unsigned addr);
    int unsigned need, start, cur, i, blk;
    bit found;
    found = 0;
    addr = 0;
    if (!heap_ready || want == 0 || free_empty) return 0;
    need = want + OVERHEAD_WORDS;
    start = free_head;
    cur = start;
    for (i = 0; i <= active_words; i++) begin
      if (cur >= active_words) break;
      if (tag_size(cur) >= int'(need)) begin
        found = 1;
        break;
      end
      cur = heap_rd(cur + 1);
      if (cur == start) break;
    end
    if (!found) return 0;
    free_head = cur;
    if (tag_size(cur) >= int'(want + 2 * OVERHEAD_WORDS + 1)) begin
      put_size(cur, tag_size(cur) - int'(need));
      blk = cur + tag_mag(cur);
      put_size(blk, int'(need));
    end else begin
      blk = cur;
      unlink_free(blk);
    end
    put_size(blk, -tag_size(blk));
    heap_wr(blk + 1, 0);
    heap_wr(blk + 2, 0);
    addr = blk + 3;
    return 1;
  endfunction

  function automatic bit heap_release(int unsigned addr);
    int unsigned b, s;
    if (!heap_ready || addr < 3) return 0;
    b = addr - 3;
    if (!block_is_live(b)) return 0;
    put_size(b, -tag_size(b));
    coalesce_right(b);
    push_free(b);
    if (b > 0) begin
      s = tag_mag(b - 1);
      if (s > 0 && s <= b && tag_size(b - s) > 0) coalesce_right(b - s);
    end
    return 1;
  endfunction

  function automatic bit heap_format();
    int unsigned w;
    w = pool_cfg;
    if (w > HEAP_WORDS) w = HEAP_WORDS;
    if (w <= OVERHEAD_WORDS) return 0;
    active_words = w;
    put_size(0, w);
    heap_wr(1, 0);
    heap_wr(2, 0);
    free_head = 0;
    free_empty = 0;
    push_free(0);
    heap_ready = 1;
    return 1;
  endfunction

  function automatic void predict_outcome(request_t r);
    outcome_t o;
    int unsigned a;
    bit ok;
    a = 0;
    case (r.op)
      OP_ALLOC: begin
        ok = heap_alloc(r.words, a);
        if (ok) live_addrs.push_back(a[FLD_W-1:0]);
      end
      OP_FREE: ok = heap_release(r.addr);
      OP_INIT: begin
        ok = heap_format();
        if (ok) live_addrs.delete();
      end
      default: begin
        heap_ready = 0;
        ok = 1;
      end
    endcase
    o.status = !ok;
    o.payload = ok ? a[FLD_W-1:0] : '0;
    outcome_q.push_back(o);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.opcode <= '0;
      req.request_words <= '0;
      req.free_address <= '0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) predict_outcome(cur_req);
      if (req.valid && !req.ready) begin
        // hold until taken
      end else if (send_gap > 0) begin
        send_gap--;
        req.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        req.valid <= 1'b1;
        req.opcode <= cur_req.op;
        req.request_words <= cur_req.words;
        req.free_address <= cur_req.addr;
        if (!quiet && $urandom_range(3) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: status %0d payload_address %0d",
                 rsp.status, rsp.payload_address);
          errors++;
        end else begin
          e = outcome_q.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            errors++;
          end
          if (rsp.payload_address !== e.payload) begin
            $error("payload_address: expected %0d, got %0d", e.payload,
                   rsp.payload_address);
            errors++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet && $urandom_range(4) == 0) sink_stall = $urandom_range(1, 9);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(op_e op, int unsigned words, int unsigned addr);
    request_t r;
    r.op = op;
    r.words = words[FLD_W-1:0];
    r.addr = addr[FLD_W-1:0];
    request_q.push_back(r);
  endtask

  task automatic wait_sent();
    @(posedge clk_i);
    while (request_q.size() > 0 || req.valid) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_sent();
    while (outcome_q.size() > 0) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic set_pool_words(int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[PW_W-1:0];
    pool_cfg = v[PW_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_batch(int unsigned pool);
    int unsigned k, sel, idx;
    for (k = 0; k < 8; k++) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        case ($urandom_range(9))
          0: add_req(OP_ALLOC, $urandom_range(4095), 0);
          1: add_req(OP_ALLOC, $urandom_range(pool), 0);
          2: add_req(OP_ALLOC, 0, $urandom_range(4095));
          default: add_req(OP_ALLOC, $urandom_range(1, 24), $urandom_range(4095));
        endcase
      end else if (sel < 92) begin
        if (live_addrs.size() > 0 && $urandom_range(6) != 0) begin
          idx = $urandom_range(live_addrs.size() - 1);
          add_req(OP_FREE, $urandom_range(4095), live_addrs[idx]);
          // leave an occasional stale copy behind to provoke a double free
          if ($urandom_range(7) != 0) live_addrs.delete(idx);
        end else begin
          add_req(OP_FREE, 0, $urandom_range(4095));
        end
      end else if (sel < 97) begin
        add_req(OP_INIT, $urandom_range(4095), 0);
      end else begin
        add_req(OP_DONE, 0, 0);
      end
    end
    wait_sent();
  endtask

  initial begin
    int unsigned pools[$];
    int unsigned p, b;
    quiet = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = PW_RESET;
    pool_cfg = PW_RESET;
    free_head = 0;
    free_empty = 1;
    heap_ready = 0;
    active_words = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // not yet initialised
    add_req(OP_ALLOC, 5, 0);
    add_req(OP_FREE, 0, 3);
    add_req(OP_DONE, 0, 0);
    wait_idle();
    set_pool_words(4);
    add_req(OP_INIT, 0, 0);
    wait_idle();
    set_pool_words(0);
    add_req(OP_INIT, 0, 0);
    add_req(OP_ALLOC, 1, 0);
    wait_idle();
    set_pool_words(8191);
    add_req(OP_INIT, 0, 0);
    add_req(OP_ALLOC, 0, 0);
    add_req(OP_ALLOC, 4095, 0);
    add_req(OP_ALLOC, 4092, 0);  // taken whole, empties the list
    add_req(OP_ALLOC, 1, 0);
    add_req(OP_FREE, 0, 2);
    add_req(OP_FREE, 0, 3);
    add_req(OP_FREE, 0, 3);
    add_req(OP_ALLOC, 10, 0);    // split from the right end
    add_req(OP_ALLOC, 20, 0);
    add_req(OP_FREE, 0, 4096 - 14 + 3);
    add_req(OP_FREE, 0, 4095);
    add_req(OP_DONE, 0, 0);
    add_req(OP_ALLOC, 3, 0);
    add_req(OP_FREE, 0, 4096 - 38 + 3);
    wait_idle();

    pools = '{4096, 5, 6, 9, 200, 13, 0, 4095};
    pools[6] = $urandom_range(10, 600);
    foreach (pools[i]) begin
      p = (pools[i] > 4096) ? 4096 : pools[i];
      set_pool_words(pools[i]);
      if (i == pools.size() - 1) quiet = 1;
      add_req(OP_INIT, 0, 0);
      wait_sent();
      for (b = 0; b < 16; b++) random_batch(p);
      wait_idle();
    end
    set_pool_words(8191);

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
